@@ src/esc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and the month length table for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int unsigned SECS_W      = 32;
   localparam int unsigned DAYS_W      = 16;
   localparam int unsigned TOD_W       = 17;
   localparam int unsigned YEAR_W      = 12;

   // 86400 is 675 shifted left by 7, so the day split divides the upper
   // 25 bits of the count by 675 with a reciprocal multiplication.
   localparam int unsigned DAY_SHIFT   = 7;
   localparam int unsigned SCALED_W    = SECS_W - DAY_SHIFT;
   localparam int unsigned RECIP_W     = 26;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam int unsigned PROD_W      = SCALED_W + RECIP_W;
   localparam int unsigned UNITS_W     = 10;

   localparam logic [UNITS_W-1:0] DAY_UNITS     = 10'd675;
   localparam logic [RECIP_W-1:0] DAY_RECIP     = 26'd50903317;
   localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
   localparam logic [6:0]         EPOCH_CENT    = 7'd70;
   localparam logic [8:0]         EPOCH_QUAD    = 9'd370;
   localparam logic [8:0]         DAYS_COMMON   = 9'd365;
   localparam logic [8:0]         DAYS_LEAP     = 9'd366;
   localparam logic [2:0]         EPOCH_WEEKDAY = 3'd4;
   localparam logic [3:0]         LAST_MONTH    = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SPLIT,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } esc_state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic split_step;
      logic year_step;
      logic month_step;
      logic tod_step;
      logic load_out;
   } esc_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic tod_done;
      logic out_busy;
   } esc_status_type;

   // Length of month idx (0 = January), with February at 29 in leap years.
   function automatic logic [4:0] month_length(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      unique case (idx)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ src/esc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath
// Day split by reciprocal multiplication, year/month subtraction,
// time-of-day split and the result register.
// ----------------------------------------------------------------------------
module esc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  esc_pkg::esc_cmd_type            cmd,
   output esc_pkg::esc_status_type         status,
   input  logic [esc_pkg::SECS_W-1:0]      req_seconds_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [11:0]                     rsp_year,
   output logic [3:0]                      rsp_month,
   output logic [4:0]                      rsp_day_of_month,
   output logic [4:0]                      rsp_hour,
   output logic [5:0]                      rsp_minute,
   output logic [5:0]                      rsp_second,
   output logic [2:0]                      rsp_weekday
);

   logic [esc_pkg::SECS_W-1:0]  dividend_ff, dividend_in;
   logic [esc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [esc_pkg::TOD_W-1:0]   tod_ff, tod_in;
   logic [esc_pkg::DAYS_W-1:0]  days_ff, days_in;
   logic [2:0]                  wk_ff, wk_in;
   logic [esc_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [6:0]                  cent_ff, cent_in;
   logic [8:0]                  quad_ff, quad_in;
   logic [3:0]                  mon_ff, mon_in;
   logic [4:0]                  hour_ff, hour_in;
   logic [5:0]                  min_ff, min_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [11:0]                 out_year_ff;
   logic [3:0]                  out_month_ff;
   logic [4:0]                  out_day_ff;
   logic [4:0]                  out_hour_ff;
   logic [5:0]                  out_min_ff;
   logic [5:0]                  out_sec_ff;
   logic [2:0]                  out_wk_ff;

   logic [esc_pkg::DAYS_W-1:0]   quot;
   logic [esc_pkg::SCALED_W-1:0] quot_back;
   logic [esc_pkg::UNITS_W-1:0]  units_left;
   logic [5:0]                   wk_digits;
   logic [3:0]                   wk_fold;
   logic                         leap;
   logic [8:0]                   year_len;
   logic [4:0]                   mon_len;
   logic [3:0]                   wk_sum;
   logic [2:0]                   wk_final;

   always_comb begin
      quot       = prod_ff[esc_pkg::RECIP_SHIFT +: esc_pkg::DAYS_W];
      quot_back  = esc_pkg::SCALED_W'(quot) * esc_pkg::SCALED_W'(esc_pkg::DAY_UNITS);
      units_left = esc_pkg::UNITS_W'(dividend_ff[esc_pkg::SECS_W-1:esc_pkg::DAY_SHIFT]
                                     - quot_back);
      // Eight is one more than seven, so the octal digits of the day count
      // add up to the same value mod 7.
      wk_digits  = {3'd0, quot[2:0]} + {3'd0, quot[5:3]} + {3'd0, quot[8:6]}
                 + {3'd0, quot[11:9]} + {3'd0, quot[14:12]} + {5'd0, quot[15]};
      wk_fold    = {1'b0, wk_digits[2:0]} + {1'b0, wk_digits[5:3]};
      leap      = (year_ff[1:0] == 2'd0) && ((cent_ff != 7'd0) || (quad_ff == 9'd0));
      year_len  = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
      mon_len   = esc_pkg::month_length(mon_ff, leap);
      wk_sum    = {1'b0, wk_ff} + {1'b0, esc_pkg::EPOCH_WEEKDAY};
      wk_final  = (wk_sum >= 4'd7) ? 3'(wk_sum - 4'd7) : wk_sum[2:0];

      status.year_done  = days_ff < {7'd0, year_len};
      status.month_done = (mon_ff == esc_pkg::LAST_MONTH) || (days_ff < {11'd0, mon_len});
      status.tod_done   = tod_ff < esc_pkg::SECS_PER_MIN;
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      dividend_in = dividend_ff;
      prod_in     = prod_ff;
      tod_in      = tod_ff;
      days_in     = days_ff;
      wk_in       = wk_ff;
      year_in     = year_ff;
      cent_in     = cent_ff;
      quad_in     = quad_ff;
      mon_in      = mon_ff;
      hour_in     = hour_ff;
      min_in      = min_ff;

      if (cmd.load) begin
         dividend_in = req_seconds_count;
         tod_in      = '0;
         days_in     = '0;
         wk_in       = '0;
         year_in     = esc_pkg::EPOCH_YEAR;
         cent_in     = esc_pkg::EPOCH_CENT;
         quad_in     = esc_pkg::EPOCH_QUAD;
         mon_in      = '0;
         hour_in     = '0;
         min_in      = '0;
      end
      if (cmd.mul_step) begin
         prod_in = esc_pkg::PROD_W'(dividend_ff[esc_pkg::SECS_W-1:esc_pkg::DAY_SHIFT])
                 * esc_pkg::PROD_W'(esc_pkg::DAY_RECIP);
      end
      if (cmd.split_step) begin
         days_in = quot;
         tod_in  = {units_left, dividend_ff[esc_pkg::DAY_SHIFT-1:0]};
         wk_in   = (wk_fold >= 4'd7) ? 3'(wk_fold - 4'd7) : wk_fold[2:0];
      end
      if (cmd.year_step) begin
         days_in = days_ff - {7'd0, year_len};
         year_in = year_ff + 12'd1;
         cent_in = (cent_ff == 7'd99) ? 7'd0 : cent_ff + 7'd1;
         quad_in = (quad_ff == 9'd399) ? 9'd0 : quad_ff + 9'd1;
      end
      if (cmd.month_step) begin
         days_in = days_ff - {11'd0, mon_len};
         mon_in  = mon_ff + 4'd1;
      end
      // Hours are counted out before minutes, so both loops share one register.
      if (cmd.tod_step) begin
         if (tod_ff >= esc_pkg::SECS_PER_HOUR) begin
            tod_in  = tod_ff - esc_pkg::SECS_PER_HOUR;
            hour_in = hour_ff + 5'd1;
         end else if (tod_ff >= esc_pkg::SECS_PER_MIN) begin
            tod_in = tod_ff - esc_pkg::SECS_PER_MIN;
            min_in = min_ff + 6'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      prod_ff     <= prod_in;
      tod_ff      <= tod_in;
      days_ff     <= days_in;
      wk_ff       <= wk_in;
      year_ff     <= year_in;
      cent_ff     <= cent_in;
      quad_ff     <= quad_in;
      mon_ff      <= mon_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_year_ff  <= year_ff;
         out_month_ff <= mon_ff + 4'd1;
         out_day_ff   <= days_ff[4:0] + 5'd1;
         out_hour_ff  <= hour_ff;
         out_min_ff   <= min_ff;
         out_sec_ff   <= tod_ff[5:0];
         out_wk_ff    <= wk_final;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_min_ff;
   assign rsp_second       = out_sec_ff;
   assign rsp_weekday      = out_wk_ff;

endmodule

@@ src/esc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer for the converter: day split, year loop, month loop, then hand
// the item to the result register.
// ----------------------------------------------------------------------------
module esc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output esc_pkg::esc_cmd_type     cmd,
   input  esc_pkg::esc_status_type  status
);

   esc_pkg::esc_state_type            state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= esc_pkg::ST_IDLE;
      end else begin
         state_ff   <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = esc_pkg::ST_DIVIDE;
            end
         end
         esc_pkg::ST_DIVIDE: begin
            cmd.mul_step = 1'b1;
            state_in     = esc_pkg::ST_SPLIT;
         end
         esc_pkg::ST_SPLIT: begin
            cmd.split_step = 1'b1;
            state_in       = esc_pkg::ST_YEAR;
         end
         // The time-of-day split runs alongside the calendar loops.
         esc_pkg::ST_YEAR: begin
            cmd.tod_step = 1'b1;
            if (status.year_done) begin
               state_in = esc_pkg::ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         esc_pkg::ST_MONTH: begin
            cmd.tod_step = 1'b1;
            if (status.month_done) begin
               state_in = esc_pkg::ST_FINISH;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         esc_pkg::ST_FINISH: begin
            cmd.tod_step = 1'b1;
            if (status.tod_done && !status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = esc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esc_pkg::ST_IDLE;
         end
      endcase
   end

   a_month_after_year: assert property (@(posedge clock) disable iff (reset)
      (state_ff == esc_pkg::ST_MONTH) |-> status.year_done)
      else $error("month loop running with whole years left");

   a_load_out_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (status.tod_done && !status.out_busy))
      else $error("result loaded before time split finished or over a waiting item");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == esc_pkg::ST_IDLE))
      else $error("input ready while an item is being converted");

endmodule

@@ src/epoch_seconds_to_calendar_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts seconds since 1970-01-01 00:00:00 to Gregorian date, time of day
// and weekday (0 = Sunday).
// ----------------------------------------------------------------------------
// One item is converted at a time. The unit accepts it, multiplies by the
// reciprocal of the day length, forms the day number, time of day and
// weekday, subtracts whole years and then whole months from the day
// number, and finally loads the result register. Hours and minutes are
// counted out in parallel with the loops; for early dates that count can
// hold the final state. A result that still waits on rsp_ready also holds
// the final state. The result register lets the next item be accepted
// while the previous result still waits on rsp_ready.
module epoch_seconds_to_calendar_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seconds_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday
);

   esc_pkg::esc_cmd_type     cmd;
   esc_pkg::esc_status_type  status;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   esc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_seconds_count (req_seconds_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

endmodule
